// File: rtl/core/rspu_pkg.sv
// Package for the range-sum / point-update tree: field widths, defaults,
// opcode and status codes and the sequencer state type. No dependencies.
`default_nettype none

package rspu_pkg;

  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SUM_W    = 42;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 11;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;
  localparam int unsigned VALUE_BITS_DEF   = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET   = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_REVERSED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_LEAF,
    ST_SET_UP,
    ST_Q_LEFT,
    ST_Q_RIGHT
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/rspu_mem.sv
// Partial-sum storage: one write port and one read port with registered data.
// Depends on rspu_pkg for the sum width.
`default_nettype none

module rspu_mem #(
  parameter int unsigned MAX_ELEMENTS = rspu_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [$clog2(2*MAX_ELEMENTS)-1:0]     waddr_i,
  input  wire logic signed [rspu_pkg::SUM_W-1:0]     wdata_i,
  input  wire logic [$clog2(2*MAX_ELEMENTS)-1:0]     raddr_i,
  output logic signed [rspu_pkg::SUM_W-1:0]          rdata_o
);

  localparam int unsigned DEPTH = 2 * MAX_ELEMENTS;

  logic signed [rspu_pkg::SUM_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/rspu_seq.sv
// Sequencer and shared adder of the tree: clearing pass, set walk to the
// root and bottom-up query walk. Depends on rspu_pkg and drives rspu_mem.
`default_nettype none

module rspu_seq #(
  parameter int unsigned MAX_ELEMENTS = rspu_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned VALUE_BITS   = rspu_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  input  wire logic [rspu_pkg::OPCODE_W-1:0]         opcode_i,
  input  wire logic [rspu_pkg::POS_W-1:0]            index_i,
  input  wire logic signed [rspu_pkg::VALUE_W-1:0]   value_i,
  input  wire logic [rspu_pkg::POS_W-1:0]            range_left_i,
  input  wire logic [rspu_pkg::POS_W-1:0]            range_right_i,
  input  wire logic [rspu_pkg::LEN_W-1:0]            array_length_i,
  output logic                                       busy,
  output logic                                       done_o,
  output logic signed [rspu_pkg::SUM_W-1:0]          range_sum_o,
  output logic [rspu_pkg::STATUS_W-1:0]              status_o,
  output logic                                       mem_we_o,
  output logic [$clog2(2*MAX_ELEMENTS)-1:0]          mem_waddr_o,
  output logic signed [rspu_pkg::SUM_W-1:0]          mem_wdata_o,
  output logic [$clog2(2*MAX_ELEMENTS)-1:0]          mem_raddr_o,
  input  wire logic signed [rspu_pkg::SUM_W-1:0]     mem_rdata_i
);

  localparam int unsigned SUM_W   = rspu_pkg::SUM_W;
  localparam int unsigned NODE_W  = $clog2(2 * MAX_ELEMENTS);
  localparam int unsigned IDX_W   = NODE_W + 1;
  localparam int unsigned MAXL_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CMP_W   = (MAXL_W > rspu_pkg::LEN_W) ? MAXL_W : rspu_pkg::LEN_W;
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(2 * MAX_ELEMENTS - 1);
  localparam logic [IDX_W-1:0]  LEAF_BASE = IDX_W'(MAX_ELEMENTS);
  localparam logic [IDX_W-1:0]  ROOT      = IDX_W'(1);

  rspu_pkg::state_e state_q, state_d;

  logic [NODE_W-1:0]          clr_q, clr_d;
  logic [IDX_W-1:0]           a_q, a_d;
  logic [IDX_W-1:0]           b_q, b_d;
  logic signed [SUM_W-1:0]    acc_q, acc_d;
  logic                       pend_q, pend_d;
  logic                       done_q, done_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [rspu_pkg::STATUS_W-1:0] status_q, status_d;

  logic [CMP_W-1:0]           len_ext;
  logic [CMP_W-1:0]           live_len;
  logic [CMP_W-1:0]           idx_ext;
  logic [CMP_W-1:0]           lo_ext;
  logic [CMP_W-1:0]           hi_ext;
  logic                       is_set;
  logic                       err_range;
  logic                       err_rev;
  logic                       err_any;
  logic signed [SUM_W-1:0]    value_ext;
  logic signed [SUM_W-1:0]    add_res;
  logic signed [SUM_W-1:0]    acc_now;
  logic [IDX_W-1:0]           parent;

  assign len_ext   = CMP_W'(array_length_i);
  assign live_len  = (len_ext > CMP_W'(MAX_ELEMENTS)) ? CMP_W'(MAX_ELEMENTS) : len_ext;
  assign idx_ext   = CMP_W'(index_i);
  assign lo_ext    = CMP_W'(range_left_i);
  assign hi_ext    = CMP_W'(range_right_i);
  assign is_set    = (rspu_pkg::opcode_e'(opcode_i) == rspu_pkg::OP_SET);
  assign err_range = is_set ? (idx_ext >= live_len)
                            : ((lo_ext >= live_len) || (hi_ext >= live_len));
  assign err_rev   = !is_set && (lo_ext > hi_ext);
  assign err_any   = err_range || err_rev;
  assign value_ext = {{(SUM_W - VALUE_BITS){value_i[VALUE_BITS-1]}},
                      value_i[VALUE_BITS-1:0]};

  assign add_res = acc_q + mem_rdata_i;
  assign acc_now = pend_q ? add_res : acc_q;
  assign parent  = a_q >> 1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rspu_pkg::ST_CLEAR: begin
        if (clr_q == LAST_NODE) begin
          state_d = rspu_pkg::ST_IDLE;
        end
      end
      rspu_pkg::ST_IDLE: begin
        if (start && !err_any) begin
          state_d = is_set ? rspu_pkg::ST_SET_LEAF : rspu_pkg::ST_Q_LEFT;
        end
      end
      rspu_pkg::ST_SET_LEAF: begin
        state_d = rspu_pkg::ST_SET_UP;
      end
      rspu_pkg::ST_SET_UP: begin
        if (parent == ROOT) begin
          state_d = rspu_pkg::ST_IDLE;
        end
      end
      rspu_pkg::ST_Q_LEFT: begin
        state_d = (a_q < b_q) ? rspu_pkg::ST_Q_RIGHT : rspu_pkg::ST_IDLE;
      end
      rspu_pkg::ST_Q_RIGHT: begin
        state_d = rspu_pkg::ST_Q_LEFT;
      end
      default: begin
        state_d = rspu_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    clr_d       = clr_q;
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    pend_d      = pend_q;
    done_d      = 1'b0;
    sum_d       = sum_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_raddr_o = '0;
    unique case (state_q)
      rspu_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + NODE_W'(1);
      end
      rspu_pkg::ST_IDLE: begin
        if (start) begin
          if (err_any) begin
            done_d   = 1'b1;
            sum_d    = '0;
            status_d = err_range ? rspu_pkg::STATUS_RANGE : rspu_pkg::STATUS_REVERSED;
          end else if (is_set) begin
            a_d   = IDX_W'(idx_ext) + LEAF_BASE;
            acc_d = value_ext;
          end else begin
            a_d    = IDX_W'(lo_ext) + LEAF_BASE;
            b_d    = IDX_W'(hi_ext) + LEAF_BASE + IDX_W'(1);
            acc_d  = '0;
            pend_d = 1'b0;
          end
        end
      end
      rspu_pkg::ST_SET_LEAF: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = a_q[NODE_W-1:0];
        mem_wdata_o = acc_q;
        mem_raddr_o = a_q[NODE_W-1:0] ^ NODE_W'(1);
      end
      rspu_pkg::ST_SET_UP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = parent[NODE_W-1:0];
        mem_wdata_o = add_res;
        mem_raddr_o = parent[NODE_W-1:0] ^ NODE_W'(1);
        acc_d       = add_res;
        a_d         = parent;
        if (parent == ROOT) begin
          done_d   = 1'b1;
          sum_d    = '0;
          status_d = rspu_pkg::STATUS_OK;
        end
      end
      rspu_pkg::ST_Q_LEFT: begin
        acc_d = acc_now;
        if (a_q < b_q) begin
          if (a_q[0]) begin
            mem_raddr_o = a_q[NODE_W-1:0];
            a_d         = a_q + IDX_W'(1);
            pend_d      = 1'b1;
          end else begin
            pend_d = 1'b0;
          end
        end else begin
          done_d   = 1'b1;
          sum_d    = acc_now;
          status_d = rspu_pkg::STATUS_OK;
        end
      end
      rspu_pkg::ST_Q_RIGHT: begin
        acc_d = acc_now;
        if (b_q[0]) begin
          mem_raddr_o = NODE_W'(b_q - IDX_W'(1));
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        a_d = a_q >> 1;
        b_d = b_q >> 1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rspu_pkg::ST_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    acc_q    <= acc_d;
    sum_q    <= sum_d;
    status_q <= status_d;
  end

  assign busy        = (state_q != rspu_pkg::ST_IDLE);
  assign done_o      = done_q;
  assign range_sum_o = sum_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// File: rtl/core/range_sum_point_update_tree_top.sv
// Top level of the range-sum / point-update tree: length register, sequencer
// and partial-sum memory. Depends on rspu_pkg, rspu_seq and rspu_mem.
//
//   Channel   Handshake             Payload
//   command   start / busy          opcode_i index_i value_i range_left_i range_right_i
//   result    done_o (one cycle)    range_sum_o status_o
//   config    cfg_we_i              cfg_data_i (array_length)
//
// After reset a clearing pass zeroes all 2*MAX_ELEMENTS tree nodes, one per
// cycle, with busy high; configuration writes are taken during it.
// A set writes the leaf and then each ancestor up to the root, one memory
// access per tree level on the single read port. A query climbs the tree
// bottom-up, alternating a left and a right step per level. A rejected transaction
// answers in the next cycle. The result strobe cannot be stalled.
`default_nettype none

module range_sum_point_update_tree_top #(
  parameter int unsigned MAX_ELEMENTS = rspu_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned VALUE_BITS   = rspu_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [rspu_pkg::OPCODE_W-1:0]         opcode_i,
  input  wire logic [rspu_pkg::POS_W-1:0]            index_i,
  input  wire logic signed [rspu_pkg::VALUE_W-1:0]   value_i,
  input  wire logic [rspu_pkg::POS_W-1:0]            range_left_i,
  input  wire logic [rspu_pkg::POS_W-1:0]            range_right_i,
  output logic                                       done_o,
  output logic signed [rspu_pkg::SUM_W-1:0]          range_sum_o,
  output logic [rspu_pkg::STATUS_W-1:0]              status_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [rspu_pkg::LEN_W-1:0]            cfg_data_i
);

  localparam int unsigned NODE_W = $clog2(2 * MAX_ELEMENTS);

  logic [rspu_pkg::LEN_W-1:0]        array_length_q;
  logic                              mem_we;
  logic [NODE_W-1:0]                 mem_waddr;
  logic signed [rspu_pkg::SUM_W-1:0] mem_wdata;
  logic [NODE_W-1:0]                 mem_raddr;
  logic signed [rspu_pkg::SUM_W-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      array_length_q <= rspu_pkg::LEN_RESET;
    end else if (cfg_we_i) begin
      array_length_q <= cfg_data_i;
    end
  end

  rspu_seq #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .opcode_i       (opcode_i),
    .index_i        (index_i),
    .value_i        (value_i),
    .range_left_i   (range_left_i),
    .range_right_i  (range_right_i),
    .array_length_i (array_length_q),
    .busy           (busy),
    .done_o         (done_o),
    .range_sum_o    (range_sum_o),
    .status_o       (status_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  rspu_mem #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for range_sum_point_update_tree_top: directed table, then random
// sets and range queries over several array lengths, each result checked against a behavioral
// array model or the table's expected status. Depends on rspu_pkg and the RTL top level only.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rspu_pkg::*;

  localparam int unsigned ELEMS          = MAX_ELEMENTS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned DRAIN_CYCLES   = 32;
  localparam int unsigned PHASES         = 8;

  typedef struct {
    opcode_e                     op;
    logic [POS_W-1:0]            idx;
    logic signed [VALUE_W-1:0]   val;
    logic [POS_W-1:0]            lo;
    logic [POS_W-1:0]            hi;
  } tree_cmd_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    status_e                 st;
  } tree_answer_t;

  typedef enum bit {ROW_CMD, ROW_LEN} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    tree_cmd_t        cmd;
    logic [LEN_W-1:0] len;
    bit               typed;
    status_e          st;
  } dir_row_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       start         = 1'b0;
  logic                       busy;
  logic [OPCODE_W-1:0]        opcode_i      = OP_SET;
  logic [POS_W-1:0]           index_i       = '0;
  logic signed [VALUE_W-1:0]  value_i       = '0;
  logic [POS_W-1:0]           range_left_i  = '0;
  logic [POS_W-1:0]           range_right_i = '0;
  logic                       done_o;
  logic signed [SUM_W-1:0]    range_sum_o;
  logic [STATUS_W-1:0]        status_o;
  logic                       cfg_we_i      = 1'b0;
  logic [LEN_W-1:0]           cfg_data_i    = '0;

  longint           elem_val [ELEMS];
  logic [LEN_W-1:0] len_reg = LEN_RESET;

  tree_answer_t pending_answers [$];
  dir_row_t     dir_rows [$];

  bit          typed_on     = 1'b0;
  status_e     typed_status = STATUS_OK;
  int unsigned burst_left   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned fail_count   = 0;
  int unsigned sets_sent    = 0;
  int unsigned queries_sent = 0;
  int unsigned errs_seen    = 0;
  int unsigned len_writes   = 0;

  range_sum_point_update_tree_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .index_i       (index_i),
    .value_i       (value_i),
    .range_left_i  (range_left_i),
    .range_right_i (range_right_i),
    .done_o        (done_o),
    .range_sum_o   (range_sum_o),
    .status_o      (status_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned usable_len();
    int unsigned n;
    n = len_reg;
    return (n > ELEMS) ? ELEMS : n;
  endfunction

  function automatic tree_answer_t work_out_answer(opcode_e op, logic [POS_W-1:0] idx,
                                                   logic signed [VALUE_W-1:0] val,
                                                   logic [POS_W-1:0] lo,
                                                   logic [POS_W-1:0] hi);
    tree_answer_t a;
    longint       acc;
    int unsigned  n;
    n     = usable_len();
    acc   = 0;
    a.sum = '0;
    a.st  = STATUS_OK;
    if (op == OP_SET) begin
      if (idx >= n) a.st = STATUS_RANGE;
      else elem_val[idx] = longint'(val);
    end else if (lo >= n || hi >= n) begin
      a.st = STATUS_RANGE;
    end else if (lo > hi) begin
      a.st = STATUS_REVERSED;
    end else begin
      for (int unsigned k = lo; k <= hi; k++) acc += elem_val[k];
      a.sum = acc[SUM_W-1:0];
    end
    return a;
  endfunction

  function automatic tree_cmd_t make_cmd();
    tree_cmd_t   c;
    int unsigned n;
    int unsigned roll;
    int unsigned a;
    int unsigned b;
    n     = usable_len();
    c.op  = ($urandom_range(0, 99) < 45) ? OP_SET : OP_QUERY;
    c.idx = POS_W'($urandom_range(0, ELEMS - 1));
    c.val = $urandom;
    c.lo  = POS_W'($urandom_range(0, ELEMS - 1));
    c.hi  = POS_W'($urandom_range(0, ELEMS - 1));
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 3))
        0: c.val = 32'sh8000_0000;
        1: c.val = 32'sh7fff_ffff;
        2: c.val = '0;
        default: c.val = -1;
      endcase
    end
    roll = $urandom_range(0, 99);
    if (c.op == OP_SET) begin
      if (roll < 85 && n > 0) c.idx = POS_W'($urandom_range(0, n - 1));
    end else if (roll < 10 && n > 0) begin
      c.lo = '0;
      c.hi = POS_W'(n - 1);
    end else if (roll < 75 && n > 0) begin
      a    = $urandom_range(0, n - 1);
      b    = $urandom_range(0, n - 1);
      c.lo = POS_W'((a < b) ? a : b);
      c.hi = POS_W'((a < b) ? b : a);
    end else if (roll < 88 && n > 1) begin
      a    = $urandom_range(0, n - 2);
      b    = $urandom_range(a + 1, n - 1);
      c.lo = POS_W'(b);
      c.hi = POS_W'(a);
    end
    return c;
  endfunction

  function automatic void add_cmd(opcode_e op, int unsigned idx, logic signed [VALUE_W-1:0] val,
                                  int unsigned lo, int unsigned hi, bit typed, status_e st);
    dir_row_t r;
    r.kind    = ROW_CMD;
    r.cmd.op  = op;
    r.cmd.idx = POS_W'(idx);
    r.cmd.val = val;
    r.cmd.lo  = POS_W'(lo);
    r.cmd.hi  = POS_W'(hi);
    r.len     = '0;
    r.typed   = typed;
    r.st      = st;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_len(logic [LEN_W-1:0] v);
    dir_row_t r;
    r.kind  = ROW_LEN;
    r.cmd   = '{OP_SET, '0, '0, '0, '0};
    r.len   = v;
    r.typed = 1'b0;
    r.st    = STATUS_OK;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  task automatic note_mismatch(string what);
    fail_count++;
    $display("%0t ns mismatch: %s", $realtime, what);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_answers.size() != 0 || busy);
    @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_len(logic [LEN_W-1:0] v);
    settle();
    cfg_data_i <= v;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    len_reg    = v;
    len_writes++;
  endtask

  task automatic send_cmd(tree_cmd_t c, bit typed, status_e st);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    opcode_i      <= c.op;
    index_i       <= c.idx;
    value_i       <= c.val;
    range_left_i  <= c.lo;
    range_right_i <= c.hi;
    start         <= 1'b1;
    typed_on      = typed;
    typed_status  = st;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    burst_left--;
  endtask

  // Outputs and the handshake are sampled at the falling edge, half a period away from any
  // change, so each transaction is seen exactly once before the edge that accepts it.
  always @(negedge clk_i) begin : answer_check
    tree_answer_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_answers.size() == 0) begin
          note_mismatch("result arrived with nothing pending");
        end else begin
          want = pending_answers.pop_front();
          if (range_sum_o !== want.sum)
            note_mismatch($sformatf("range_sum got %0d expected %0d", range_sum_o, want.sum));
          if (status_o !== want.st)
            note_mismatch($sformatf("status got %0d expected %0d", status_o, want.st));
          if (want.st != STATUS_OK) errs_seen++;
        end
      end
      if (start && !busy) begin
        want = work_out_answer(opcode_e'(opcode_i), index_i, value_i, range_left_i,
                               range_right_i);
        if (typed_on) begin
          want.sum = '0;
          want.st  = typed_status;
        end
        pending_answers.insert(pending_answers.size(), want);
        if (opcode_i == OP_SET) sets_sent++;
        else queries_sent++;
      end
      idle_cycles = (done_o || (start && !busy)) ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t ns no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [LEN_W-1:0] phase_len;
    int unsigned      phase_items;
    foreach (elem_val[i]) elem_val[i] = 0;

    add_cmd(OP_QUERY, 0, 0, 0, 1023, 1'b1, STATUS_OK);
    add_len(11'd1024);
    add_cmd(OP_QUERY, 0, 0, 1023, 0, 1'b1, STATUS_REVERSED);
    add_cmd(OP_SET, 0, 32'sh8000_0000, 0, 0, 1'b0, STATUS_OK);
    add_cmd(OP_SET, 1023, 32'sh7fff_ffff, 0, 0, 1'b0, STATUS_OK);
    add_cmd(OP_SET, 512, -1, 0, 0, 1'b0, STATUS_OK);
    add_cmd(OP_SET, 1, 0, 0, 0, 1'b0, STATUS_OK);
    add_cmd(OP_QUERY, 0, 0, 0, 1023, 1'b0, STATUS_OK);
    add_cmd(OP_QUERY, 0, 0, 0, 0, 1'b0, STATUS_OK);
    add_cmd(OP_QUERY, 0, 0, 1023, 1023, 1'b0, STATUS_OK);
    add_cmd(OP_QUERY, 0, 0, 511, 512, 1'b0, STATUS_OK);
    add_len(11'd2047);
    add_cmd(OP_QUERY, 0, 0, 0, 1023, 1'b0, STATUS_OK);
    add_len(11'd16);
    add_cmd(OP_SET, 16, 5, 0, 0, 1'b1, STATUS_RANGE);
    add_cmd(OP_SET, 15, 32'sh7fff_ffff, 0, 0, 1'b0, STATUS_OK);
    add_cmd(OP_QUERY, 0, 0, 0, 16, 1'b1, STATUS_RANGE);
    add_cmd(OP_QUERY, 0, 0, 16, 3, 1'b1, STATUS_RANGE);
    add_cmd(OP_QUERY, 0, 0, 15, 0, 1'b1, STATUS_REVERSED);
    add_cmd(OP_QUERY, 0, 0, 0, 15, 1'b0, STATUS_OK);
    add_len(11'd1);
    add_cmd(OP_SET, 0, 7, 0, 0, 1'b0, STATUS_OK);
    add_cmd(OP_SET, 1, 9, 0, 0, 1'b1, STATUS_RANGE);
    add_cmd(OP_QUERY, 0, 0, 0, 0, 1'b0, STATUS_OK);
    add_len(11'd0);
    add_cmd(OP_SET, 0, 3, 0, 0, 1'b1, STATUS_RANGE);
    add_cmd(OP_QUERY, 0, 0, 0, 0, 1'b1, STATUS_RANGE);
    add_len(11'd1024);
    add_cmd(OP_QUERY, 0, 0, 0, 1023, 1'b0, STATUS_OK);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LEN) write_len(dir_rows[i].len);
      else send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].st);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_len = 11'd2047;
        1: phase_len = 11'd1;
        2: phase_len = 11'd0;
        3: phase_len = 11'd2;
        4: phase_len = 11'd1024;
        5: phase_len = 11'd300;
        default: phase_len = LEN_W'($urandom_range(3, 2047));
      endcase
      write_len(phase_len);
      phase_items = (phase_len == 0) ? 25 : 118;
      repeat (phase_items) send_cmd(make_cmd(), 1'b0, STATUS_OK);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d set and %0d query transactions; %0d answered with an error status.",
             sets_sent, queries_sent, errs_seen);
    $display("Array length was written %0d times, spanning zero, one, full size and above.",
             len_writes);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
